// ===== src/icv_pkg.sv =====
// shared constants, types and register codes for the 2d convolution unit
`timescale 1ns / 1ps

package icv_pkg;

    // field widths of the item and result transactions
    localparam int PIXEL_W    = 8;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 5;
    localparam int VALUE_W    = 29;

    // default sizing of the unit
    localparam int KERNEL_MAX_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // result queue depth, power of two
    localparam int FIFO_DEPTH = 8;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_KDIM_W   = 3;

    localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RST = 13'd1024;
    localparam logic [CFG_KDIM_W-1:0]   CFG_KDIM_RST   = 3'd3;

    // item op codes
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_WIDTH  = 2'd2,
        REG_KERNEL_HEIGHT = 2'd3
    } reg_idx_t;

    // coefficient table write request
    typedef struct packed {
        logic                         en;
        logic [COEF_IDX_W-1:0]        index;
        logic signed [COEF_W-1:0]     value;
    } coef_wr_t;

endpackage

// ===== src/icv_if.sv =====
// item and result channel interfaces of the 2d convolution unit
`timescale 1ns / 1ps

interface icv_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic [icv_pkg::COEF_IDX_W-1:0]        coef_index;
    logic signed [icv_pkg::COEF_W-1:0]     coef_value;
    logic [icv_pkg::PIXEL_W-1:0]           pixel;

    modport source (output valid, op, coef_index, coef_value, pixel, input ready);
    modport sink (input valid, op, coef_index, coef_value, pixel, output ready);
endinterface

interface icv_result_if #(
    parameter int X_W = $clog2(icv_pkg::MAX_WIDTH_DEF),
    parameter int Y_W = $clog2(icv_pkg::MAX_HEIGHT_DEF)
);
    logic                                  valid;
    logic                                  ready;
    logic signed [icv_pkg::VALUE_W-1:0]    out_value;
    logic [X_W-1:0]                        out_x;
    logic [Y_W-1:0]                        out_y;
    logic                                  out_last;

    modport source (output valid, out_value, out_x, out_y, out_last, input ready);
    modport sink (input valid, out_value, out_x, out_y, out_last, output ready);
endinterface

// ===== src/icv_line_mem.sv =====
// line buffer memory, one word per column holding the previous kernel rows
`timescale 1ns / 1ps

module icv_line_mem #(
    parameter int DEPTH = icv_pkg::MAX_WIDTH_DEF,
    parameter int ROWS  = icv_pkg::KERNEL_MAX_DEF - 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [AW-1:0]                             rd_addr,
    input  logic                                      wr_en,
    input  logic [AW-1:0]                             wr_addr,
    input  logic [ROWS-1:0][icv_pkg::PIXEL_W-1:0]     wr_data,
    output logic [ROWS-1:0][icv_pkg::PIXEL_W-1:0]     rd_data
);

    logic [ROWS-1:0][icv_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [ROWS-1:0][icv_pkg::PIXEL_W-1:0] q_reg;
    logic [ROWS-1:0][icv_pkg::PIXEL_W-1:0] fwd_data_reg;
    logic                                  fwd_hit_reg;

    // read-first port pair
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg        <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // same-cycle write to the entry being read: forward the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

// ===== src/icv_window_mac.sv =====
// window registers, coefficient table and the pipelined multiply-accumulate tree
`timescale 1ns / 1ps

module icv_window_mac #(
    parameter int KERNEL_MAX = icv_pkg::KERNEL_MAX_DEF,
    localparam int KW_W      = $clog2(KERNEL_MAX + 1)
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          shift_en,
    input  logic [KERNEL_MAX-1:0][icv_pkg::PIXEL_W-1:0]   column,
    input  icv_pkg::coef_wr_t                             coef_wr,
    input  logic [KW_W-1:0]                               kw,
    input  logic [KW_W-1:0]                               kh,
    output logic signed [icv_pkg::VALUE_W-1:0]            total
);

    localparam int NTAP  = KERNEL_MAX * KERNEL_MAX;
    localparam int CI_W  = (NTAP > 1) ? $clog2(NTAP) : 1;
    localparam int PW    = icv_pkg::PIXEL_W + 1 + icv_pkg::COEF_W;
    localparam int ROW_W = PW + $clog2(KERNEL_MAX);
    localparam int TOT_W = ROW_W + $clog2(KERNEL_MAX);

    logic [icv_pkg::PIXEL_W-1:0]        win_reg  [KERNEL_MAX][KERNEL_MAX];
    logic signed [icv_pkg::COEF_W-1:0]  coef_reg [NTAP];
    logic signed [icv_pkg::COEF_W-1:0]  tap_coef [KERNEL_MAX][KERNEL_MAX];
    logic signed [PW-1:0]               prod_next [KERNEL_MAX][KERNEL_MAX];
    logic signed [PW-1:0]               prod_reg  [KERNEL_MAX][KERNEL_MAX];
    logic signed [ROW_W-1:0]            row_next [KERNEL_MAX];
    logic signed [ROW_W-1:0]            row_reg  [KERNEL_MAX];
    logic signed [TOT_W-1:0]            tot_sum;

    // index 0 is the newest row and the newest column
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int k = 0; k < KERNEL_MAX; k++)
            begin
                for (int d = KERNEL_MAX - 1; d >= 1; d--)
                begin
                    win_reg[k][d] <= win_reg[k][d-1];
                end
                win_reg[k][0] <= column[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NTAP; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_wr.en && (32'(coef_wr.index) < 32'(NTAP)))
        begin
            coef_reg[CI_W'(coef_wr.index)] <= coef_wr.value;
        end
    end

    // coefficient that meets each window tap; taps outside the kernel get zero
    always_comb
    begin
        int ky;
        int kx;
        int idx;
        for (int dr = 0; dr < KERNEL_MAX; dr++)
        begin
            for (int dc = 0; dc < KERNEL_MAX; dc++)
            begin
                ky  = int'(kh) - 1 - dr;
                kx  = int'(kw) - 1 - dc;
                idx = ky * int'(kw) + kx;
                if ((dr < int'(kh)) && (dc < int'(kw)))
                begin
                    tap_coef[dr][dc] = coef_reg[CI_W'(idx)];
                end
                else
                begin
                    tap_coef[dr][dc] = '0;
                end
            end
        end
    end

    // taps outside the kernel add nothing, whatever the window holds there
    always_comb
    begin
        for (int dr = 0; dr < KERNEL_MAX; dr++)
        begin
            for (int dc = 0; dc < KERNEL_MAX; dc++)
            begin
                if ((dr < int'(kh)) && (dc < int'(kw)))
                begin
                    prod_next[dr][dc] = $signed({1'b0, win_reg[dr][dc]}) * tap_coef[dr][dc];
                end
                else
                begin
                    prod_next[dr][dc] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int dr = 0; dr < KERNEL_MAX; dr++)
        begin
            row_next[dr] = '0;
            for (int dc = 0; dc < KERNEL_MAX; dc++)
            begin
                row_next[dr] = row_next[dr] + ROW_W'(prod_reg[dr][dc]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        row_reg  <= row_next;
    end

    always_comb
    begin
        tot_sum = '0;
        for (int dr = 0; dr < KERNEL_MAX; dr++)
        begin
            tot_sum = tot_sum + TOT_W'(row_reg[dr]);
        end
    end

    assign total = icv_pkg::VALUE_W'(tot_sum);

endmodule

// ===== src/icv_out_fifo.sv =====
// result queue between the convolution pipeline and the output channel
`timescale 1ns / 1ps

module icv_out_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = icv_pkg::FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     push_data,
    input  logic             pop,
    output logic             valid,
    output logic [W-1:0]     data,
    output logic [CNT_W-1:0] count
);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign valid = (count_reg != '0);
    assign data  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== src/image_convolution_2d_unit.sv =====
// top level of the streaming 2d convolution unit with line buffers
// path: a result is offered once its pixel transaction has passed stages a to d and entered the result queue
// throughput: one transaction per cycle, set by the line memory's one read and one write
// per cycle; item ready drops only when queued results plus in-flight transactions reach 8
// reset: counters and coefficients clear, registers take their defaults; line memory
// is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module image_convolution_2d_unit #(
    parameter int KERNEL_MAX = icv_pkg::KERNEL_MAX_DEF,
    parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = icv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    icv_item_if.sink                        item,
    icv_result_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [icv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [icv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [icv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int KW_W  = $clog2(KERNEL_MAX + 1);
    localparam int LR    = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
    localparam int RES_W = icv_pkg::VALUE_W + XW + YW + 1;
    localparam int CNT_W = $clog2(icv_pkg::FIFO_DEPTH + 1);

    // configuration registers
    logic [icv_pkg::CFG_WIDTH_W-1:0]  cfg_width_reg;
    logic [icv_pkg::CFG_HEIGHT_W-1:0] cfg_height_reg;
    logic [icv_pkg::CFG_KDIM_W-1:0]   cfg_kw_reg;
    logic [icv_pkg::CFG_KDIM_W-1:0]   cfg_kh_reg;
    logic                             cfg_wr;
    icv_pkg::reg_idx_t                cfg_idx;

    // effective (clamped) frame and kernel sizes
    logic [XW:0]     w_lim;
    logic [YW:0]     h_lim;
    logic [KW_W-1:0] kw_c;
    logic [KW_W-1:0] kh_c;

    // raster position of the next pixel
    logic [XW-1:0] col_cnt_reg;
    logic [YW-1:0] row_cnt_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_next;
    logic [XW-1:0] col_pos;
    logic [YW-1:0] row_pos;

    // per-pixel result decision
    logic          res_hit;
    logic [XW-1:0] res_x;
    logic [YW-1:0] res_y;
    logic          res_last;

    logic item_acc;
    logic pix_acc;

    // stage a: line memory data returns, window shifts
    logic                                  a_valid_reg;
    logic                                  a_op_reg;
    logic [icv_pkg::PIXEL_W-1:0]           a_pixel_reg;
    logic [icv_pkg::COEF_IDX_W-1:0]        a_coef_index_reg;
    logic signed [icv_pkg::COEF_W-1:0]     a_coef_value_reg;
    logic [XW-1:0]                         a_col_reg;
    logic                                  a_res_reg;
    logic [XW-1:0]                         a_x_reg;
    logic [YW-1:0]                         a_y_reg;
    logic                                  a_last_reg;

    // stage b: products, coefficient writes land here
    logic                                  b_valid_reg;
    logic                                  b_op_reg;
    logic [icv_pkg::COEF_IDX_W-1:0]        b_coef_index_reg;
    logic signed [icv_pkg::COEF_W-1:0]     b_coef_value_reg;
    logic                                  b_res_reg;
    logic [XW-1:0]                         b_x_reg;
    logic [YW-1:0]                         b_y_reg;
    logic                                  b_last_reg;

    // stage c: row sums
    logic                                  c_valid_reg;
    logic                                  c_res_reg;
    logic [XW-1:0]                         c_x_reg;
    logic [YW-1:0]                         c_y_reg;
    logic                                  c_last_reg;

    // stage d: final sum, pushed into the queue
    logic                                  d_valid_reg;
    logic                                  d_res_reg;
    logic [XW-1:0]                         d_x_reg;
    logic [YW-1:0]                         d_y_reg;
    logic                                  d_last_reg;

    // line memory and window datapath
    logic [LR-1:0][icv_pkg::PIXEL_W-1:0]         lm_rd_data;
    logic [LR-1:0][icv_pkg::PIXEL_W-1:0]         lm_wr_data;
    logic                                        lm_wr_en;
    logic [KERNEL_MAX-1:0][icv_pkg::PIXEL_W-1:0] column;
    logic                                        win_shift;
    icv_pkg::coef_wr_t                           coef_wr;
    logic signed [icv_pkg::VALUE_W-1:0]          mac_total;

    // result queue
    logic             fifo_push;
    logic [RES_W-1:0] fifo_push_data;
    logic             fifo_pop;
    logic             fifo_valid;
    logic [RES_W-1:0] fifo_data;
    logic [CNT_W-1:0] fifo_count;

    //--------------------------------------------------------------------------
    // configuration port: write on the access phase, reads are combinational
    //--------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = icv_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= icv_pkg::CFG_WIDTH_RST;
            cfg_height_reg <= icv_pkg::CFG_HEIGHT_RST;
            cfg_kw_reg     <= icv_pkg::CFG_KDIM_RST;
            cfg_kh_reg     <= icv_pkg::CFG_KDIM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                icv_pkg::REG_IMAGE_WIDTH:   cfg_width_reg  <= pwdata[icv_pkg::CFG_WIDTH_W-1:0];
                icv_pkg::REG_IMAGE_HEIGHT:  cfg_height_reg <= pwdata[icv_pkg::CFG_HEIGHT_W-1:0];
                icv_pkg::REG_KERNEL_WIDTH:  cfg_kw_reg     <= pwdata[icv_pkg::CFG_KDIM_W-1:0];
                icv_pkg::REG_KERNEL_HEIGHT: cfg_kh_reg     <= pwdata[icv_pkg::CFG_KDIM_W-1:0];
                default:                    cfg_width_reg  <= cfg_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            icv_pkg::REG_IMAGE_WIDTH:   prdata = icv_pkg::APB_DATA_W'(cfg_width_reg);
            icv_pkg::REG_IMAGE_HEIGHT:  prdata = icv_pkg::APB_DATA_W'(cfg_height_reg);
            icv_pkg::REG_KERNEL_WIDTH:  prdata = icv_pkg::APB_DATA_W'(cfg_kw_reg);
            icv_pkg::REG_KERNEL_HEIGHT: prdata = icv_pkg::APB_DATA_W'(cfg_kh_reg);
            default:                    prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------------
    // clamp the sizes: zero counts as one, too large counts as the maximum,
    // an even kernel size drops to the next odd one
    //--------------------------------------------------------------------------
    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            w_lim = (XW + 1)'(1);
        end
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
        begin
            w_lim = (XW + 1)'(MAX_WIDTH);
        end
        else
        begin
            w_lim = (XW + 1)'(cfg_width_reg);
        end

        if (cfg_height_reg == '0)
        begin
            h_lim = (YW + 1)'(1);
        end
        else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_lim = (YW + 1)'(MAX_HEIGHT);
        end
        else
        begin
            h_lim = (YW + 1)'(cfg_height_reg);
        end

        if (cfg_kw_reg == '0)
        begin
            kw_c = KW_W'(1);
        end
        else if (32'(cfg_kw_reg) > 32'(KERNEL_MAX))
        begin
            kw_c = KW_W'(KERNEL_MAX);
        end
        else
        begin
            kw_c = KW_W'(cfg_kw_reg);
        end
        if (!kw_c[0])
        begin
            kw_c = kw_c - KW_W'(1);
        end

        if (cfg_kh_reg == '0)
        begin
            kh_c = KW_W'(1);
        end
        else if (32'(cfg_kh_reg) > 32'(KERNEL_MAX))
        begin
            kh_c = KW_W'(KERNEL_MAX);
        end
        else
        begin
            kh_c = KW_W'(cfg_kh_reg);
        end
        if (!kh_c[0])
        begin
            kh_c = kh_c - KW_W'(1);
        end
    end

    //--------------------------------------------------------------------------
    // raster position, result decision and counter advance
    //--------------------------------------------------------------------------
    assign item_acc = item.valid && item.ready;
    assign pix_acc  = item_acc && (item.op == icv_pkg::OP_PIXEL);

    always_comb
    begin
        col_pos = (32'(col_cnt_reg) >= 32'(MAX_WIDTH)) ? '0 : col_cnt_reg;
        row_pos = (32'(row_cnt_reg) >= 32'(MAX_HEIGHT)) ? '0 : row_cnt_reg;

        // window complete and centre inside the image
        res_hit = (32'(col_pos) + 32'd1 >= 32'(kw_c))
               && (32'(row_pos) + 32'd1 >= 32'(kh_c))
               && (32'(col_pos) < 32'(w_lim))
               && (32'(row_pos) < 32'(h_lim));
        res_x    = XW'(32'(col_pos) - 32'(kw_c >> 1));
        res_y    = YW'(32'(row_pos) - 32'(kh_c >> 1));
        res_last = (32'(col_pos) + 32'd1 == 32'(w_lim))
                && (32'(row_pos) + 32'd1 == 32'(h_lim));

        if (32'(col_pos) + 32'd1 >= 32'(w_lim))
        begin
            col_next = '0;
            row_next = (32'(row_pos) + 32'd1 >= 32'(h_lim)) ? '0 : YW'(32'(row_pos) + 32'd1);
        end
        else
        begin
            col_next = XW'(32'(col_pos) + 32'd1);
            row_next = row_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_cnt_reg <= col_next;
            row_cnt_reg <= row_next;
        end
    end

    // accept while the queue has room for every transaction already in flight
    assign item.ready = (32'(fifo_count) + 32'(a_valid_reg) + 32'(b_valid_reg)
                         + 32'(c_valid_reg) + 32'(d_valid_reg)) < 32'(icv_pkg::FIFO_DEPTH);

    //--------------------------------------------------------------------------
    // pipeline: valid bits reset, payload does not
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= item_acc;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg         <= item.op;
        a_pixel_reg      <= item.pixel;
        a_coef_index_reg <= item.coef_index;
        a_coef_value_reg <= item.coef_value;
        a_col_reg        <= col_pos;
        a_res_reg        <= (item.op == icv_pkg::OP_PIXEL) && res_hit;
        a_x_reg          <= res_x;
        a_y_reg          <= res_y;
        a_last_reg       <= res_last;

        b_op_reg         <= a_op_reg;
        b_coef_index_reg <= a_coef_index_reg;
        b_coef_value_reg <= a_coef_value_reg;
        b_res_reg        <= a_res_reg;
        b_x_reg          <= a_x_reg;
        b_y_reg          <= a_y_reg;
        b_last_reg       <= a_last_reg;

        c_res_reg        <= b_res_reg;
        c_x_reg          <= b_x_reg;
        c_y_reg          <= b_y_reg;
        c_last_reg       <= b_last_reg;

        d_res_reg        <= c_res_reg;
        d_x_reg          <= c_x_reg;
        d_y_reg          <= c_y_reg;
        d_last_reg       <= c_last_reg;
    end

    //--------------------------------------------------------------------------
    // line memory: read at acceptance, read-modify-write in stage a
    //--------------------------------------------------------------------------
    icv_line_mem #(
        .DEPTH (MAX_WIDTH),
        .ROWS  (LR)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (col_pos),
        .wr_en   (lm_wr_en),
        .wr_addr (a_col_reg),
        .wr_data (lm_wr_data),
        .rd_data (lm_rd_data)
    );

    assign lm_wr_en  = a_valid_reg && (a_op_reg == icv_pkg::OP_PIXEL);
    assign win_shift = lm_wr_en;

    // new column, newest row first; stored rows move down by one
    always_comb
    begin
        column[0] = a_pixel_reg;
        for (int k = 1; k < KERNEL_MAX; k++)
        begin
            column[k] = lm_rd_data[k-1];
        end
        lm_wr_data[0] = a_pixel_reg;
        for (int k = 1; k < LR; k++)
        begin
            lm_wr_data[k] = lm_rd_data[k-1];
        end
    end

    // coefficient writes take effect in stage b, in order with the products
    always_comb
    begin
        coef_wr.en    = b_valid_reg && (b_op_reg == icv_pkg::OP_COEF);
        coef_wr.index = b_coef_index_reg;
        coef_wr.value = b_coef_value_reg;
    end

    icv_window_mac #(
        .KERNEL_MAX (KERNEL_MAX)
    ) u_window_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .column   (column),
        .coef_wr  (coef_wr),
        .kw       (kw_c),
        .kh       (kh_c),
        .total    (mac_total)
    );

    //--------------------------------------------------------------------------
    // result queue and output channel
    //--------------------------------------------------------------------------
    assign fifo_push      = d_valid_reg && d_res_reg;
    assign fifo_push_data = {mac_total, d_x_reg, d_y_reg, d_last_reg};
    assign fifo_pop       = result.valid && result.ready;

    icv_out_fifo #(
        .W     (RES_W),
        .DEPTH (icv_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_push_data),
        .pop       (fifo_pop),
        .valid     (fifo_valid),
        .data      (fifo_data),
        .count     (fifo_count)
    );

    assign result.valid     = fifo_valid;
    assign result.out_value = fifo_data[RES_W-1 -: icv_pkg::VALUE_W];
    assign result.out_x     = fifo_data[YW+XW : YW+1];
    assign result.out_y     = fifo_data[YW:1];
    assign result.out_last  = fifo_data[0];

endmodule
